[design/tksl_pkg.sv]
`default_nettype none

package tksl_pkg;

	localparam int MAX_K       = 8;
	localparam int HANDLE_BITS = 16;
	localparam int SCORE_W     = 16;
	localparam int IDX_W       = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int CNT_W       = 4;
	localparam int KIND_W      = 2;

	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GET   = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

[design/tksl_ctrl.sv]
`default_nettype none

module tksl_ctrl
	import tksl_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.exec;
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

[design/tksl_dp.sv]
`default_nettype none

module tksl_dp
	import tksl_pkg::*;
(
	input  wire                           clk,
	input  wire                           arst_n,
	input  cmd_t                          cmd,
	input  wire        [KIND_W-1:0]       kind,
	input  wire        [HANDLE_BITS-1:0]  cand_handle,
	input  wire signed [SCORE_W-1:0]      cand_score,
	input  wire        [CNT_W-1:0]        rank_index,
	input  wire                           cfg_we,
	input  wire        [CNT_W-1:0]        cfg_wdata,
	output logic                          hit,
	output logic       [HANDLE_BITS-1:0]  entry_handle,
	output logic       [CNT_W-1:0]        entry_count
);

	// captured transaction
	logic        [KIND_W-1:0]      kind_q;
	logic        [HANDLE_BITS-1:0] hdl_q;
	logic signed [SCORE_W-1:0]     scr_q;
	logic        [CNT_W-1:0]       rank_q;

	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] fill_q;

	// list cells, rank 0 first
	logic signed [SCORE_W-1:0]     sc_q [MAX_K];
	logic        [HANDLE_BITS-1:0] hd_q [MAX_K];

	logic                          hit_q;
	logic        [HANDLE_BITS-1:0] ehdl_q;

	logic                          not_full;
	logic        [CNT_W-1:0]       pos;
	logic                          add_ok;
	logic        [MAX_K-1:0]       ins_ok;
	logic                          get_hit;
	logic        [CNT_W-1:0]       k_wr;

	always_comb begin
		not_full = (fill_q < k_q);
		pos      = not_full ? fill_q : fill_q - CNT_W'(1);
		add_ok   = not_full ||
			((fill_q != '0) && (scr_q > sc_q[pos[IDX_W-1:0]]));
		// cell i takes part in the shift when the new score is not below it
		for (int i = 0; i < MAX_K; i++) begin
			ins_ok[i] = (CNT_W'(i) == pos) ||
				((CNT_W'(i) < pos) && !(sc_q[i] > scr_q));
		end
		get_hit = (rank_q < fill_q) && (rank_q < k_q);
	end

	always_comb begin
		k_wr = cfg_wdata;
		if (cfg_wdata == '0) k_wr = CNT_W'(1);
		else if (cfg_wdata > CNT_W'(MAX_K)) k_wr = CNT_W'(MAX_K);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= CNT_W'(MAX_K);
			fill_q <= '0;
		end else if (cfg_we) begin
			k_q    <= k_wr;
			fill_q <= '0;
		end else if (cmd.exec) begin
			if (kind_q == KIND_CLEAR) fill_q <= '0;
			else if ((kind_q == KIND_ADD) && not_full) fill_q <= fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			hdl_q  <= cand_handle;
			scr_q  <= cand_score;
			rank_q <= rank_index;
		end
		if (cmd.exec && (kind_q == KIND_ADD) && add_ok) begin
			for (int i = 0; i < MAX_K; i++) begin
				if (ins_ok[i]) begin
					if (i == 0) begin
						sc_q[i] <= scr_q;
						hd_q[i] <= hdl_q;
					end else if (!ins_ok[(i == 0) ? 0 : i - 1]) begin
						sc_q[i] <= scr_q;
						hd_q[i] <= hdl_q;
					end else begin
						sc_q[i] <= sc_q[(i == 0) ? 0 : i - 1];
						hd_q[i] <= hd_q[(i == 0) ? 0 : i - 1];
					end
				end
			end
		end
		if (cmd.exec) begin
			hit_q  <= (kind_q == KIND_GET) && get_hit;
			ehdl_q <= ((kind_q == KIND_GET) && get_hit) ?
				hd_q[rank_q[IDX_W-1:0]] : '0;
		end
	end

	assign hit          = hit_q;
	assign entry_handle = ehdl_q;
	assign entry_count  = fill_q;

endmodule

`default_nettype wire

[design/top_k_score_list.sv]
// sequencing: a start taken in idle loads the transaction, the exec state applies it,
//   and the result is registered, with done raised in the cycle after exec
// overlap: a new start is not taken while the controller is in its exec step;
//   busy is high for that one exec cycle and start may be raised again with done
// reset: arst_n low clears the controller, the entry count and sets k to 8;
//   list cells hold no reset value. results cannot be stalled by the receiver
`default_nettype none

module top_k_score_list
	import tksl_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	// transaction request
	input  wire                          start,
	output logic                         busy,
	input  wire        [KIND_W-1:0]      kind,
	input  wire        [HANDLE_BITS-1:0] cand_handle,
	input  wire signed [SCORE_W-1:0]     cand_score,
	input  wire        [CNT_W-1:0]       rank_index,
	// k register write, also empties the list
	input  wire                          cfg_we,
	input  wire        [CNT_W-1:0]       cfg_wdata,
	// result, valid for the single cycle of done
	output logic                         done,
	output logic                         hit,
	output logic       [HANDLE_BITS-1:0] entry_handle,
	output logic       [CNT_W-1:0]       entry_count
);

	cmd_t cmd;

	// controller: idle / exec sequencing and the done strobe
	tksl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath: list cells with parallel compare and shift insert,
	// rank lookup, count and k registers
	tksl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.cand_handle  (cand_handle),
		.cand_score   (cand_score),
		.rank_index   (rank_index),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.hit          (hit),
		.entry_handle (entry_handle),
		.entry_count  (entry_count)
	);

	// a result never shows while a transaction is in exec
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a taken transaction occupies exactly one exec cycle, then reports
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("exec did not complete in one cycle");

	// a miss carries a zero handle
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (entry_handle == '0))
		else $error("nonzero handle on miss");

	// the list never holds more than its cell count
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CNT_W'(MAX_K))
		else $error("entry count above capacity");

endmodule

`default_nettype wire

[verif/top_k_list_checker.sv]
module top_k_list_checker
	import tksl_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          busy,
	input  wire        [KIND_W-1:0]      kind,
	input  wire        [HANDLE_BITS-1:0] cand_handle,
	input  wire signed [SCORE_W-1:0]     cand_score,
	input  wire        [CNT_W-1:0]       rank_index,
	input  wire                          cfg_we,
	input  wire        [CNT_W-1:0]       cfg_wdata,
	input  wire                          done,
	input  wire                          hit,
	input  wire        [HANDLE_BITS-1:0] entry_handle,
	input  wire        [CNT_W-1:0]       entry_count,
	output int                           fail_count,
	output int                           owed
);

	typedef struct packed {
		logic                   hit;
		logic [HANDLE_BITS-1:0] handle;
		logic [CNT_W-1:0]       count;
	} list_reply_t;

	// shadow of the ranked list, rank 0 holds the best score
	logic signed [SCORE_W-1:0] rank_score [MAX_K];
	logic [HANDLE_BITS-1:0]    rank_handle [MAX_K];
	int                        held;
	int                        k_keep;
	list_reply_t               owed_replies [$];

	task automatic insert_candidate(input logic [HANDLE_BITS-1:0] h,
			input logic signed [SCORE_W-1:0] s);
		int                        pos;
		logic signed [SCORE_W-1:0] ts;
		logic [HANDLE_BITS-1:0]    th;
		if (held < k_keep) begin
			pos = held;
			held++;
		end else begin
			if (held == 0)
				return;
			pos = held - 1;
			// full list: only a strictly better score displaces the last entry
			if (!(s > rank_score[pos]))
				return;
		end
		rank_score[pos]  = s;
		rank_handle[pos] = h;
		// newest wins ties, so bubble up past equal scores too
		while (pos > 0 && rank_score[pos] >= rank_score[pos-1]) begin
			ts                 = rank_score[pos];
			th                 = rank_handle[pos];
			rank_score[pos]    = rank_score[pos-1];
			rank_handle[pos]   = rank_handle[pos-1];
			rank_score[pos-1]  = ts;
			rank_handle[pos-1] = th;
			pos--;
		end
	endtask

	task automatic predict_list_reply(output list_reply_t r);
		r = '0;
		case (kind)
			KIND_ADD:   insert_candidate(cand_handle, cand_score);
			KIND_CLEAR: held = 0;
			KIND_GET: begin
				if (rank_index < k_keep && rank_index < held) begin
					r.hit    = 1'b1;
					r.handle = rank_handle[rank_index[IDX_W-1:0]];
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(held);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_reply_t exp_r;
		list_reply_t new_r;
		if (!arst_n) begin
			held       = 0;
			k_keep     = (MAX_K < 8) ? MAX_K : 8;
			fail_count = 0;
			owed_replies.delete();
			owed       = 0;
		end else begin
			if (done) begin
				if (owed_replies.size() == 0) begin
					$display("%0t unexpected result: hit %0d handle %h count %0d",
						$time, hit, entry_handle, entry_count);
					fail_count++;
				end else begin
					exp_r = owed_replies.pop_front();
					if (hit !== exp_r.hit) begin
						$display("%0t hit mismatch: expected %0d, actual %0d",
							$time, exp_r.hit, hit);
						fail_count++;
					end
					if (entry_handle !== exp_r.handle) begin
						$display("%0t entry_handle mismatch: expected %h, actual %h",
							$time, exp_r.handle, entry_handle);
						fail_count++;
					end
					if (entry_count !== exp_r.count) begin
						$display("%0t entry_count mismatch: expected %0d, actual %0d",
							$time, exp_r.count, entry_count);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				// out of range k saturates, and any write empties the list
				k_keep = (cfg_wdata == 0) ? 1 : ((cfg_wdata > MAX_K) ? MAX_K : cfg_wdata);
				held   = 0;
			end
			if (start && !busy) begin
				predict_list_reply(new_r);
				owed_replies.push_back(new_r);
			end
			owed = owed_replies.size();
		end
	end

endmodule

[verif/tb_top_k_score_list.sv]
module tb_top_k_score_list;
	import tksl_pkg::*;

	// kind code that the block takes and ignores
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	// number of counted random transactions per k setting
	localparam int PHASE_TXNS = 152;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          start       = 1'b0;
	logic        [KIND_W-1:0]      kind        = KIND_ADD;
	logic        [HANDLE_BITS-1:0] cand_handle = '0;
	logic signed [SCORE_W-1:0]     cand_score  = '0;
	logic        [CNT_W-1:0]       rank_index  = '0;
	logic                          cfg_we      = 1'b0;
	logic        [CNT_W-1:0]       cfg_wdata   = '0;
	wire                           busy;
	wire                           done;
	wire                           hit;
	wire         [HANDLE_BITS-1:0] entry_handle;
	wire         [CNT_W-1:0]       entry_count;
	int                            mismatches;
	int                            replies_owed;

	// when set, transactions go back to back with start held high
	bit                            no_gaps;

	always #6 clk = ~clk;

	top_k_score_list u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.cand_handle  (cand_handle),
		.cand_score   (cand_score),
		.rank_index   (rank_index),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.hit          (hit),
		.entry_handle (entry_handle),
		.entry_count  (entry_count)
	);

	// watches both channels, predicts every result and compares
	top_k_list_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.cand_handle  (cand_handle),
		.cand_score   (cand_score),
		.rank_index   (rank_index),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.hit          (hit),
		.entry_handle (entry_handle),
		.entry_count  (entry_count),
		.fail_count   (mismatches),
		.owed         (replies_owed)
	);

	// one transaction: optional idle gap, then hold start until busy is low
	// at a rising edge; returns on the falling edge after the handshake
	task automatic send_txn(input logic [KIND_W-1:0] k, input logic [HANDLE_BITS-1:0] h,
			input logic signed [SCORE_W-1:0] s, input logic [CNT_W-1:0] r);
		int gap;
		bit took;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       <= 1'b1;
		kind        <= k;
		cand_handle <= h;
		cand_score  <= s;
		rank_index  <= r;
		do begin
			@(posedge clk);
			took = !busy;
			@(negedge clk);
		end while (!took);
	endtask

	// let every owed result come back before touching the k register
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (replies_owed != 0);
	endtask

	// k write while idle, one cycle of write enable
	task automatic write_k(input logic [CNT_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random score: mostly a narrow band so ties and displacements are common
	function automatic logic signed [SCORE_W-1:0] pick_score();
		int pick;
		int narrow;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			narrow = $urandom_range(0, 6) - 3;
			return narrow[SCORE_W-1:0];
		end
		if (pick < 80)
			return SCORE_W'($urandom);
		case ($urandom_range(0, 3))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sh8001;
			default: return 16'sh7ffe;
		endcase
	endfunction

	// a random transaction; ignored kinds do not count toward the phase
	task automatic random_txn(output bit counted);
		int                    pick;
		logic [KIND_W-1:0]     k;
		logic [CNT_W-1:0]      r;
		pick    = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 50)
			k = KIND_ADD;
		else if (pick < 89)
			k = KIND_GET;
		else if (pick < 95)
			k = KIND_CLEAR;
		else begin
			k       = KIND_NOP;
			counted = 1'b0;
		end
		// ranks mostly near the list size, sometimes far beyond it
		r = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(0, 8)) : CNT_W'($urandom);
		send_txn(k, HANDLE_BITS'($urandom), pick_score(), r);
	endtask

	// reset, directed and random stimulus, verdict and run end
	initial begin
		bit                   counted;
		int                   sent;
		logic [CNT_W-1:0]     k_plan [8];
		k_plan = '{4'd8, 4'd1, 4'd2, 4'd15, 4'd0, 4'd3, 4'd5, 4'd7};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, k at its reset value of 8
		no_gaps = 1'b0;
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd0);   // get on empty list
		send_txn(KIND_NOP, 16'hffff, 16'sh7fff, 4'd15);  // ignored kind
		send_txn(KIND_ADD, 16'h0000, 16'sh8000, 4'd0);   // lowest score
		send_txn(KIND_ADD, 16'hffff, 16'sh7fff, 4'd0);   // highest score
		send_txn(KIND_ADD, 16'h1111, 16'sh0005, 4'd0);
		send_txn(KIND_ADD, 16'h2222, 16'sh0005, 4'd0);   // tie, newer ranks above
		send_txn(KIND_ADD, 16'h3333, 16'sh8000, 4'd0);   // tie at the bottom
		no_gaps = 1'b1;
		send_txn(KIND_ADD, 16'h4444, 16'sh0000, 4'd0);
		send_txn(KIND_ADD, 16'h5555, 16'sh0000, 4'd0);
		send_txn(KIND_ADD, 16'h6666, 16'sh0064, 4'd0);   // list now full
		send_txn(KIND_ADD, 16'h7777, 16'sh8000, 4'd0);   // not greater, dropped
		send_txn(KIND_ADD, 16'h8888, 16'sh8001, 4'd0);   // displaces the last
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd0);
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd7);
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd8);   // beyond k
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd15);
		send_txn(KIND_CLEAR, 16'hffff, 16'sh7fff, 4'd15);
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd0);   // miss after clear

		// k of zero acts as one
		write_k(4'd0);
		send_txn(KIND_ADD, 16'habcd, 16'sh000a, 4'd0);
		send_txn(KIND_ADD, 16'h1234, 16'sh000a, 4'd0);   // equal on full list
		send_txn(KIND_ADD, 16'h5678, 16'sh000b, 4'd0);   // greater replaces
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd0);
		send_txn(KIND_GET, 16'h0000, 16'sh0000, 4'd1);   // beyond k and count

		// random phases, one k setting each, extremes included
		for (int p = 0; p < 8; p++) begin
			write_k(k_plan[p]);
			sent = 0;
			while (sent < PHASE_TXNS) begin
				// switch between bursts and gapped traffic now and then
				if (sent % 24 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				random_txn(counted);
				if (counted)
					sent++;
			end
		end

		drain();
		// keep the clock running to catch a stray result
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
